### hdl/dcd_pkg.sv
// shared types and constants of the chunk dispatcher
`timescale 1ns / 1ps

package dcd_pkg;

  localparam int DEV_W   = 4;
  localparam int CIDX_W  = 10;
  localparam int FIELD_W = 32;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    CMD_START    = 2'd0,
    CMD_REQUEST  = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_RING_FULL  = 2'd1,
    STATUS_TABLE_FULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL_SIZE       = 2'd0,
    REG_CHUNK_SIZE       = 2'd1,
    REG_FIRST_CHUNK_SIZE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              command;
    logic [DEV_W-1:0]  device_id;
    logic [CIDX_W-1:0] chunk_index;
  } in_req_t;

  typedef struct packed {
    logic               dispatch_valid;
    logic [DEV_W-1:0]   out_device;
    logic [CIDX_W-1:0]  out_chunk_index;
    logic [FIELD_W-1:0] chunk_offset;
    logic [FIELD_W-1:0] chunk_length;
    logic               request_popped;
    logic               queued;
    logic               all_done;
    status_t            status;
  } out_rsp_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

endpackage

### hdl/dcd_chunk_table.sv
// chunk owner and length memory, one write and one registered read per cycle
`timescale 1ns / 1ps

module dcd_chunk_table #(
  parameter int MAX_CHUNKS = 1024,
  parameter int SIZE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_CHUNKS)-1:0] rd_addr,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_CHUNKS)-1:0] wr_addr,
  input  logic [dcd_pkg::DEV_W-1:0]     wr_owner,
  input  logic [SIZE_BITS-1:0]          wr_len,
  output logic [dcd_pkg::DEV_W-1:0]     rd_owner,
  output logic [SIZE_BITS-1:0]          rd_len
);

  localparam int ENTRY_W = dcd_pkg::DEV_W + SIZE_BITS;

  logic [ENTRY_W-1:0] mem [MAX_CHUNKS];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [ENTRY_W-1:0] wr_data;

  assign wr_data = {wr_owner, wr_len};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      // new entry written in the same cycle is forwarded
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_owner = rd_data_r[ENTRY_W-1 -: dcd_pkg::DEV_W];
  assign rd_len   = rd_data_r[SIZE_BITS-1:0];

endmodule

### hdl/dcd_request_ring.sv
// circular queue of pending device requests
`timescale 1ns / 1ps

module dcd_request_ring #(
  parameter int RING_DEPTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  dcd_pkg::ring_ctrl_t       ctrl,
  input  logic [dcd_pkg::DEV_W-1:0] push_dev,
  output dcd_pkg::ring_stat_t       stat,
  output logic [dcd_pkg::DEV_W-1:0] head_dev
);

  localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RING_DEPTH);

  logic [dcd_pkg::DEV_W-1:0] ring_r [RING_DEPTH];
  logic [PTR_W-1:0]          wr_ptr_r;
  logic [PTR_W-1:0]          rd_ptr_r;
  logic [CNT_W-1:0]          count_r;

  assign stat.full  = (count_r == CNT_FULL);
  assign stat.empty = (count_r == '0);
  assign head_dev   = ring_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else if (ctrl.clear) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else if (ctrl.push) begin
      wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      count_r  <= count_r + 1'b1;
    end else if (ctrl.pop) begin
      rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      count_r  <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push && !ctrl.clear) begin
      ring_r[wr_ptr_r] <= push_dev;
    end
  end

endmodule

### hdl/dynamic_chunk_dispatcher_unit.sv
// top level of the chunk dispatcher: request register, event logic and result register
`timescale 1ns / 1ps

// Takes one command request per clock cycle while in_ready is high and returns
// exactly one result per request, held in the result register while stalled. A
// request is first held in an input register while the chunk table memory is
// read at its chunk index; the event logic then updates the counters, the
// request ring and the table in one pass and loads the result register. The
// chunk table has one write and one read port, so when nothing stalls it takes one
// request per cycle. Table entries are not cleared at reset; completing a
// chunk that was never issued gives an undefined owner and length. The input
// stays ready while a result waits, until the input register is also held.

module dynamic_chunk_dispatcher_unit #(
  parameter int DEVICES    = 16,
  parameter int RING_DEPTH = 32,
  parameter int MAX_CHUNKS = 1024,
  parameter int SIZE_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dcd_pkg::FIELD_W-1:0]   cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dcd_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dcd_pkg::out_rsp_t             out_data
);

  localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

  logic [SIZE_BITS-1:0] total_size_r;
  logic [SIZE_BITS-1:0] chunk_size_r;
  logic [SIZE_BITS-1:0] first_chunk_size_r;

  logic                 s1_valid_r;
  dcd_pkg::in_req_t     s1_req_r;
  logic                 out_valid_r;
  dcd_pkg::out_rsp_t    out_data_r;

  logic [SIZE_BITS-1:0] unissued_r, unissued_nxt;
  logic [SIZE_BITS-1:0] uncompleted_r, uncompleted_nxt;
  logic [SIZE_BITS-1:0] offset_r, offset_nxt;
  logic [CNT_W-1:0]     issued_r, issued_nxt;

  logic                 in_acc;
  logic                 advance;

  dcd_pkg::ring_ctrl_t       ring_ctrl;
  dcd_pkg::ring_stat_t       ring_stat;
  logic [dcd_pkg::DEV_W-1:0] ring_push_dev;
  logic [dcd_pkg::DEV_W-1:0] ring_head;

  logic                      tbl_wr_en;
  logic [dcd_pkg::DEV_W-1:0] tbl_owner;
  logic [SIZE_BITS-1:0]      tbl_len;

  logic                      dev_ok;
  logic                      cidx_ok;
  logic [SIZE_BITS-1:0]      unc_left;
  logic [SIZE_BITS-1:0]      len_sel;
  logic [SIZE_BITS-1:0]      len_cut;
  logic                      push_req;
  dcd_pkg::out_rsp_t         rsp;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_size_r       <= '0;
      chunk_size_r       <= SIZE_BITS'(1);
      first_chunk_size_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dcd_pkg::REG_TOTAL_SIZE:       total_size_r       <= SIZE_BITS'(cfg_wdata);
        dcd_pkg::REG_CHUNK_SIZE:       chunk_size_r       <= SIZE_BITS'(cfg_wdata);
        dcd_pkg::REG_FIRST_CHUNK_SIZE: first_chunk_size_r <= SIZE_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  dcd_chunk_table #(
    .MAX_CHUNKS (MAX_CHUNKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_table (
    .clk      (clk),
    .rd_en    (in_acc),
    .rd_addr  (IDX_W'(in_data.chunk_index)),
    .wr_en    (tbl_wr_en),
    .wr_addr  (IDX_W'(issued_r)),
    .wr_owner (ring_head),
    .wr_len   (len_cut),
    .rd_owner (tbl_owner),
    .rd_len   (tbl_len)
  );

  dcd_request_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ring_ctrl),
    .push_dev (ring_push_dev),
    .stat     (ring_stat),
    .head_dev (ring_head)
  );

  assign dev_ok   = (32'(s1_req_r.device_id) < 32'(DEVICES));
  assign cidx_ok  = (32'(s1_req_r.chunk_index) < 32'(MAX_CHUNKS));
  assign unc_left = (tbl_len >= uncompleted_r) ? '0 : uncompleted_r - tbl_len;
  assign len_sel  = (issued_r == '0) ? first_chunk_size_r : chunk_size_r;
  assign len_cut  = (len_sel > unissued_r) ? unissued_r : len_sel;

  // event logic
  always_comb begin
    unissued_nxt    = unissued_r;
    uncompleted_nxt = uncompleted_r;
    offset_nxt      = offset_r;
    issued_nxt      = issued_r;
    push_req        = 1'b0;
    ring_ctrl       = '0;
    ring_push_dev   = s1_req_r.device_id;
    tbl_wr_en       = 1'b0;
    rsp             = '0;
    rsp.status      = dcd_pkg::STATUS_OK;

    unique case (s1_req_r.command)
      dcd_pkg::CMD_START: begin
        unissued_nxt    = total_size_r;
        uncompleted_nxt = total_size_r;
        offset_nxt      = '0;
        issued_nxt      = '0;
        ring_ctrl.clear = 1'b1;
      end
      dcd_pkg::CMD_REQUEST: begin
        push_req = dev_ok && (uncompleted_r != '0);
      end
      dcd_pkg::CMD_COMPLETE: begin
        if (cidx_ok) begin
          uncompleted_nxt = unc_left;
          ring_push_dev   = tbl_owner;
          push_req        = (unc_left != '0);
        end
      end
      dcd_pkg::CMD_DISPATCH: begin
        if (!ring_stat.empty) begin
          ring_ctrl.pop      = 1'b1;
          rsp.request_popped = 1'b1;
          rsp.out_device     = ring_head;
          if (unissued_r != '0) begin
            if (32'(issued_r) >= 32'(MAX_CHUNKS)) begin
              rsp.status = dcd_pkg::STATUS_TABLE_FULL;
            end else begin
              tbl_wr_en           = 1'b1;
              rsp.dispatch_valid  = 1'b1;
              rsp.out_chunk_index = dcd_pkg::CIDX_W'(issued_r);
              rsp.chunk_offset    = dcd_pkg::FIELD_W'(offset_r);
              rsp.chunk_length    = dcd_pkg::FIELD_W'(len_cut);
              offset_nxt          = offset_r + len_cut;
              unissued_nxt        = unissued_r - len_cut;
              issued_nxt          = issued_r + 1'b1;
            end
          end
        end
      end
      default: ;
    endcase

    if (push_req) begin
      if (ring_stat.full) begin
        rsp.status = dcd_pkg::STATUS_RING_FULL;
      end else begin
        ring_ctrl.push = 1'b1;
        rsp.queued     = 1'b1;
      end
    end

    rsp.all_done = (uncompleted_nxt == '0);

    if (!advance) begin
      ring_ctrl = '0;
      tbl_wr_en = 1'b0;
    end
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      unissued_r    <= '0;
      uncompleted_r <= '0;
      offset_r      <= '0;
      issued_r      <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        unissued_r    <= unissued_nxt;
        uncompleted_r <= uncompleted_nxt;
        offset_r      <= offset_nxt;
        issued_r      <= issued_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= rsp;
    end
  end

`ifndef NO_ASSERTIONS
  a_issue_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.dispatch_valid || out_data.request_popped))
    else $error("chunk issued without a popped request");

  a_table_full_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == dcd_pkg::STATUS_TABLE_FULL)) |->
      (out_data.request_popped && !out_data.dispatch_valid))
    else $error("table full flagged on an issued chunk");

  a_queued_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.queued) |-> (out_data.status == dcd_pkg::STATUS_OK))
    else $error("queued request reported with an error status");

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled with a free stage");

  a_ring_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_ctrl.push && ring_ctrl.pop))
    else $error("ring pushed and popped in one cycle");
`endif

endmodule

### sim/tb_top.sv
// testbench for the chunk dispatcher: directed and random command requests checked against a predictor
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_CHUNKS     = 1024;
  localparam int DEVICES        = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 420;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [dcd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [dcd_pkg::FIELD_W-1:0]   cfg_wdata = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  dcd_pkg::in_req_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  dcd_pkg::out_rsp_t             out_data;

  dynamic_chunk_dispatcher_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // dispatcher image kept by the testbench
  logic [31:0] total_sz = 32'd0;
  logic [31:0] chunk_sz = 32'd1;
  logic [31:0] first_sz = 32'd0;
  logic        ring_busy [32];
  logic [3:0]  ring_dev  [32];
  logic [4:0]  wr_ptr = '0;
  logic [4:0]  rd_ptr = '0;
  logic [31:0] unissued = '0;
  logic [31:0] next_offset = '0;
  logic [31:0] remaining = '0;
  logic [10:0] n_issued = '0;
  logic [10:0] n_completed = '0;
  logic [3:0]  owner_tab [MAX_CHUNKS];
  logic [31:0] len_tab   [MAX_CHUNKS];
  bit          issued_ever [MAX_CHUNKS];

  dcd_pkg::out_rsp_t expected_rsp [$];
  logic [9:0]        live_chunks [$];
  logic [9:0]        issued_chunks [$];

  int fail_cnt     = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int gap_left     = 0;
  bit vld_up       = 1'b0;
  int stall_cycles = 0;
  int rx_mode      = 0;
  int rx_left      = 0;
  int rx_phase     = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < 32; i++) begin
      ring_busy[i] = 1'b0;
      ring_dev[i]  = '0;
    end
  end

  function automatic bit ring_push(logic [3:0] dev);
    if (ring_busy[wr_ptr]) return 1'b0;
    ring_busy[wr_ptr] = 1'b1;
    ring_dev[wr_ptr]  = dev;
    wr_ptr = wr_ptr + 1'b1;
    return 1'b1;
  endfunction

  function automatic dcd_pkg::out_rsp_t advance_dispatcher(dcd_pkg::in_req_t req);
    dcd_pkg::out_rsp_t rsp;
    logic [3:0]        dev;
    logic [31:0]       len;
    rsp = '0;
    case (req.command)
      dcd_pkg::CMD_START: begin
        unissued    = total_sz;
        remaining   = total_sz;
        next_offset = '0;
        n_issued    = '0;
        n_completed = '0;
        wr_ptr      = '0;
        rd_ptr      = '0;
        for (int i = 0; i < 32; i++) begin
          ring_busy[i] = 1'b0;
          ring_dev[i]  = '0;
        end
      end
      dcd_pkg::CMD_REQUEST: begin
        if (int'(req.device_id) < DEVICES && remaining != 0) begin
          if (ring_push(req.device_id)) rsp.queued = 1'b1;
          else rsp.status = dcd_pkg::STATUS_RING_FULL;
        end
      end
      dcd_pkg::CMD_COMPLETE: begin
        dev = owner_tab[req.chunk_index];
        len = len_tab[req.chunk_index];
        n_completed = n_completed + 1'b1;
        remaining = (len >= remaining) ? 32'd0 : remaining - len;
        if (remaining != 0) begin
          if (ring_push(dev)) rsp.queued = 1'b1;
          else rsp.status = dcd_pkg::STATUS_RING_FULL;
        end
      end
      default: begin
        if (ring_busy[rd_ptr]) begin
          dev = ring_dev[rd_ptr];
          ring_busy[rd_ptr] = 1'b0;
          ring_dev[rd_ptr]  = '0;
          rd_ptr = rd_ptr + 1'b1;
          rsp.request_popped = 1'b1;
          rsp.out_device     = dev;
          if (unissued != 0) begin
            if (n_issued >= MAX_CHUNKS) begin
              rsp.status = dcd_pkg::STATUS_TABLE_FULL;
            end else begin
              len = (n_issued == 0) ? first_sz : chunk_sz;
              if (len > unissued) len = unissued;
              owner_tab[n_issued[9:0]] = dev;
              len_tab[n_issued[9:0]]   = len;
              rsp.dispatch_valid  = 1'b1;
              rsp.out_chunk_index = n_issued[9:0];
              rsp.chunk_offset    = next_offset;
              rsp.chunk_length    = len;
              next_offset = next_offset + len;
              unissued    = unissued - len;
              n_issued    = n_issued + 1'b1;
            end
          end
        end
      end
    endcase
    rsp.all_done = (remaining == 0);
    return rsp;
  endfunction

  task automatic send_req(dcd_pkg::cmd_t cmd, logic [3:0] dev, logic [9:0] cidx);
    dcd_pkg::in_req_t  req;
    dcd_pkg::out_rsp_t want;
    req.command     = cmd;
    req.device_id   = dev;
    req.chunk_index = cidx;
    if (!vld_up) begin
      repeat (gap_left) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 300) : $urandom_range(1, 24);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    vld_up = 1'b1;
    want = advance_dispatcher(req);
    expected_rsp.insert(expected_rsp.size(), want);
    if (cmd == dcd_pkg::CMD_START) live_chunks.delete();
    if (want.dispatch_valid) begin
      live_chunks.insert(live_chunks.size(), want.out_chunk_index);
      if (!issued_ever[want.out_chunk_index]) begin
        issued_ever[want.out_chunk_index] = 1'b1;
        issued_chunks.insert(issued_chunks.size(), want.out_chunk_index);
      end
    end
    items_sent++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      vld_up = 1'b0;
      gap_left = $urandom_range(1, 16);
    end
  endtask

  // completed chunk: an open one of the current job, or any chunk issued so far
  function automatic logic [9:0] pick_done(bit from_live);
    int         k;
    logic [9:0] idx;
    if (from_live && live_chunks.size() != 0) begin
      k   = $urandom_range(0, live_chunks.size() - 1);
      idx = live_chunks[k];
      live_chunks.delete(k);
    end else begin
      idx = issued_chunks[$urandom_range(0, issued_chunks.size() - 1)];
    end
    return idx;
  endfunction

  function automatic logic [31:0] pick_size(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(1, hi);
    endcase
  endfunction

  function automatic logic [3:0] rand_dev();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [9:0] rand_idx();
    return 10'($urandom_range(0, 1023));
  endfunction

  task automatic drain();
    if (vld_up) begin
      in_valid <= 1'b0;
      vld_up = 1'b0;
    end
    @(posedge clk);
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_sizes(logic [31:0] t, logic [31:0] c, logic [31:0] f);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= dcd_pkg::REG_TOTAL_SIZE;
    cfg_wdata <= t;
    @(posedge clk);
    cfg_index <= dcd_pkg::REG_CHUNK_SIZE;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= dcd_pkg::REG_FIRST_CHUNK_SIZE;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we <= 1'b0;
    total_sz = t;
    chunk_sz = c;
    first_sz = f;
  endtask

  task automatic test_reset_state();
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd7, 10'd1023);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd15, 10'd512);
  endtask

  // first chunk of length zero, then one chunk clamped to the whole range
  task automatic test_extremes();
    program_sizes(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    send_req(dcd_pkg::CMD_START, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd15, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd9, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_COMPLETE, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_COMPLETE, 4'd0, 10'd1);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd3, 10'd0);
  endtask

  // short job, repeated completion saturates the remaining work at zero
  task automatic test_basic_job();
    program_sizes(32'd10, 32'd3, 32'd4);
    send_req(dcd_pkg::CMD_START, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd3, 10'd0);
    send_req(dcd_pkg::CMD_REQUEST, 4'd12, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_COMPLETE, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_COMPLETE, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_COMPLETE, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
    send_req(dcd_pkg::CMD_DISPATCH, 4'd0, 10'd0);
  endtask

  task automatic test_ring_overflow();
    program_sizes(32'd1000, pick_size(8), pick_size(8));
    send_req(dcd_pkg::CMD_START, rand_dev(), rand_idx());
    repeat (2) begin
      repeat ($urandom_range(34, 40)) begin
        if ($urandom_range(0, 4) == 0 && issued_chunks.size() != 0)
          send_req(dcd_pkg::CMD_COMPLETE, rand_dev(), pick_done(1'b1));
        else
          send_req(dcd_pkg::CMD_REQUEST, rand_dev(), rand_idx());
      end
      repeat ($urandom_range(30, 36))
        send_req(dcd_pkg::CMD_DISPATCH, rand_dev(), rand_idx());
    end
  endtask

  task automatic test_random_jobs();
    int target;
    int roll;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      program_sizes(pick_size(300), pick_size(40), pick_size(40));
      send_req(dcd_pkg::CMD_START, rand_dev(), rand_idx());
      repeat ($urandom_range(15, 70)) begin
        roll = $urandom_range(0, 99);
        if (roll < 30)
          send_req(dcd_pkg::CMD_REQUEST, rand_dev(), rand_idx());
        else if (roll < 60 || issued_chunks.size() == 0)
          send_req(dcd_pkg::CMD_DISPATCH, rand_dev(), rand_idx());
        else if (roll < 92)
          send_req(dcd_pkg::CMD_COMPLETE, rand_dev(), pick_done(1'b1));
        else if (roll < 97)
          send_req(dcd_pkg::CMD_COMPLETE, rand_dev(), pick_done(1'b0));
        else
          send_req(dcd_pkg::CMD_START, rand_dev(), rand_idx());
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : rsp_check
    dcd_pkg::out_rsp_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        want = expected_rsp.pop_front();
        check_field("dispatch_valid", 32'(want.dispatch_valid),
                    32'(out_data.dispatch_valid));
        check_field("out_device", 32'(want.out_device), 32'(out_data.out_device));
        check_field("out_chunk_index", 32'(want.out_chunk_index),
                    32'(out_data.out_chunk_index));
        check_field("chunk_offset", want.chunk_offset, out_data.chunk_offset);
        check_field("chunk_length", want.chunk_length, out_data.chunk_length);
        check_field("request_popped", 32'(want.request_popped),
                    32'(out_data.request_popped));
        check_field("queued", 32'(want.queued), 32'(out_data.queued));
        check_field("all_done", 32'(want.all_done), 32'(out_data.all_done));
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // result side stalls follow a mode that is picked at random and changed when its run ends
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode  = $urandom_range(0, 3);
      rx_left  = $urandom_range(32, 256);
      rx_phase = 0;
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_phase % 12) >= 5;
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_extremes();
    test_basic_job();
    test_ring_overflow();
    test_random_jobs();
    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && expected_rsp.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
